FILE: rtl/core/ccbw_pkg.sv
// Shared types, register map and helper functions for the clipped column blit writer.
// No dependencies; the position unit and the top level both import this package.
package ccbw_pkg;

	// Register indexes on the configuration port, as paddr[4:2].
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH   = 3'd0,
		REG_SCREEN_HEIGHT  = 3'd1,
		REG_TEXTURE_WIDTH  = 3'd2,
		REG_TEXTURE_HEIGHT = 3'd3,
		REG_ORIGIN_X       = 3'd4,
		REG_ORIGIN_Y       = 3'd5
	} reg_index_t;

	localparam int unsigned CfgWidth = 12;
	localparam int unsigned PosWidth = 11;
	localparam int unsigned AddrWidth = 22;
	localparam int unsigned TexelWidth = 8;
	localparam logic [CfgWidth-1:0] TexDimLimit = 12'd2048;

	// Screen placement of one texel, handed from the position unit to the
	// address stage.
	typedef struct packed {
		logic                on;
		logic [CfgWidth-1:0] x;
		logic [CfgWidth-1:0] y;
		logic                done;
	} pos_info_t;

	// Texture size as used: zero counts as one, and sizes cap at 2048.
	function automatic logic [CfgWidth-1:0] tex_dim(input logic [CfgWidth-1:0] v);
		logic [CfgWidth-1:0] r;
		if (v == '0) begin
			r = CfgWidth'(1);
		end else if (v > TexDimLimit) begin
			r = TexDimLimit;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/clipped_column_blit_writer_top.sv
// Top level of the clipped column blit writer: APB register file, position unit and
// address pipeline. Depends on ccbw_pkg and ccbw_pos.

// The block takes one 8-bit texel per transaction on the slave stream, in column-major
// order and top to bottom within a column, and returns one framebuffer write per texel
// on the master stream. It sustains one texel per clock while m_tready stays high;
// stage 1 registers the texture position and the clip test, and stage 2 registers the
// one 12 by 13 bit multiply and add that forms the row-major address. Texels that
// fall off the screen are still consumed and come out with write enable low, address
// zero and the texel value unchanged, so the stream stays aligned. The last texel of
// the texture is marked by tlast, after which the counters restart at the top-left
// corner. Registers sit at byte addresses 0x00 screen width, 0x04 screen height,
// 0x08 texture width, 0x0C texture height, 0x10 origin x and 0x14 origin y (both signed);
// only bits 11:0 of a write are kept, and writes to other addresses are dropped.
// Change the registers only while no texel is in flight.
module clipped_column_blit_writer_top
	import ccbw_pkg::*;
#(
	parameter int unsigned MAX_SCREEN_DIM = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Texel input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] texel
	// Framebuffer write stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [21:0] pixel_address, [29:22] pixel_value, rest zero
	output logic        m_tuser,   // [0] write_enable
	output logic        m_tlast    // blit_done
);

	localparam logic [CfgWidth:0] ScrMax = (CfgWidth+1)'(MAX_SCREEN_DIM);

	logic [CfgWidth-1:0] screen_width_q;
	logic [CfgWidth-1:0] screen_height_q;
	logic [CfgWidth-1:0] texture_width_q;
	logic [CfgWidth-1:0] texture_height_q;
	logic [CfgWidth-1:0] origin_x_q;
	logic [CfgWidth-1:0] origin_y_q;

	logic [CfgWidth:0]   sw_eff;
	logic [CfgWidth:0]   sh_eff;
	logic                cfg_write;
	reg_index_t          cfg_index;

	pos_info_t           pos_info;
	logic                in_accept;
	logic                s1_advance;

	logic                valid_s1;
	pos_info_t           info_s1;
	logic [TexelWidth-1:0] texel_s1;

	logic                out_valid_q;
	logic                write_enable_q;
	logic [AddrWidth-1:0] pixel_address_q;
	logic [TexelWidth-1:0] pixel_value_q;
	logic                blit_done_q;
	logic [2*CfgWidth:0] product;
	logic [2*CfgWidth:0] address_full;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = reg_index_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q   <= 12'd320;
			screen_height_q  <= 12'd200;
			texture_width_q  <= 12'd1;
			texture_height_q <= 12'd1;
			origin_x_q       <= '0;
			origin_y_q       <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:   screen_width_q   <= pwdata[CfgWidth-1:0];
				REG_SCREEN_HEIGHT:  screen_height_q  <= pwdata[CfgWidth-1:0];
				REG_TEXTURE_WIDTH:  texture_width_q  <= pwdata[CfgWidth-1:0];
				REG_TEXTURE_HEIGHT: texture_height_q <= pwdata[CfgWidth-1:0];
				REG_ORIGIN_X:       origin_x_q       <= pwdata[CfgWidth-1:0];
				REG_ORIGIN_Y:       origin_y_q       <= pwdata[CfgWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			REG_SCREEN_WIDTH:   prdata = 32'(screen_width_q);
			REG_SCREEN_HEIGHT:  prdata = 32'(screen_height_q);
			REG_TEXTURE_WIDTH:  prdata = 32'(texture_width_q);
			REG_TEXTURE_HEIGHT: prdata = 32'(texture_height_q);
			REG_ORIGIN_X:       prdata = 32'(origin_x_q);
			REG_ORIGIN_Y:       prdata = 32'(origin_y_q);
			default:            prdata = '0;
		endcase
	end

	// Screen sizes above the supported maximum are treated as the maximum.
	assign sw_eff = ({1'b0, screen_width_q} > ScrMax) ? ScrMax : {1'b0, screen_width_q};
	assign sh_eff = ({1'b0, screen_height_q} > ScrMax) ? ScrMax : {1'b0, screen_height_q};

	// Pipeline flow: the output register frees when its transaction is taken, and
	// stage 1 moves on whenever the output register can take it.
	assign s1_advance = !out_valid_q || m_tready;
	assign s_tready   = !valid_s1 || s1_advance;
	assign in_accept  = s_tvalid && s_tready;

	ccbw_pos u_pos (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (in_accept),
		.texture_width     (texture_width_q),
		.texture_height    (texture_height_q),
		.screen_width_eff  (sw_eff),
		.screen_height_eff (sh_eff),
		.origin_x          ($signed(origin_x_q)),
		.origin_y          ($signed(origin_y_q)),
		.info              (pos_info)
	);

	// Stage 1: placement and clip result of the accepted texel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			info_s1  <= pos_info;
			texel_s1 <= s_tdata;
		end
	end

	// Stage 2: row-major address. Clipped texels get address zero.
	assign product      = (2*CfgWidth+1)'(info_s1.y) * (2*CfgWidth+1)'(sw_eff);
	assign address_full = product + (2*CfgWidth+1)'(info_s1.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && valid_s1) begin
			write_enable_q  <= info_s1.on;
			pixel_address_q <= info_s1.on ? address_full[AddrWidth-1:0] : '0;
			pixel_value_q   <= texel_s1;
			blit_done_q     <= info_s1.done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, pixel_value_q, pixel_address_q};
	assign m_tuser  = write_enable_q;
	assign m_tlast  = blit_done_q;

endmodule

FILE: rtl/core/ccbw_pos.sv
// Texture row and column counters and the clip test for the current texel.
// Depends on ccbw_pkg for the field widths, pos_info_t and tex_dim().
module ccbw_pos
	import ccbw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [CfgWidth-1:0]        texture_width,
	input  logic [CfgWidth-1:0]        texture_height,
	input  logic [CfgWidth:0]          screen_width_eff,
	input  logic [CfgWidth:0]          screen_height_eff,
	input  logic signed [CfgWidth-1:0] origin_x,
	input  logic signed [CfgWidth-1:0] origin_y,
	output pos_info_t                  info
);

	logic [PosWidth-1:0] row_q;
	logic [PosWidth-1:0] col_q;
	logic [CfgWidth-1:0] tw;
	logic [CfgWidth-1:0] th;
	logic [CfgWidth-1:0] row_inc;
	logic [CfgWidth-1:0] col_inc;
	logic                last_row;
	logic                last_col;
	logic signed [CfgWidth:0] x;
	logic signed [CfgWidth:0] y;

	always_comb begin
		tw = tex_dim(texture_width);
		th = tex_dim(texture_height);
		row_inc = {1'b0, row_q} + CfgWidth'(1);
		col_inc = {1'b0, col_q} + CfgWidth'(1);
		// A counter beyond a shrunken size still counts as the last row or column.
		last_row = (row_inc >= th);
		last_col = (col_inc >= tw);
		x = (CfgWidth+1)'(origin_x) + $signed({2'b00, col_q});
		y = (CfgWidth+1)'(origin_y) + $signed({2'b00, row_q});
		info.on = !x[CfgWidth] && !y[CfgWidth]
			&& ({1'b0, x[CfgWidth-1:0]} < screen_width_eff)
			&& ({1'b0, y[CfgWidth-1:0]} < screen_height_eff);
		info.x = x[CfgWidth-1:0];
		info.y = y[CfgWidth-1:0];
		info.done = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (last_row && last_col) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_row) begin
				row_q <= '0;
				col_q <= col_inc[PosWidth-1:0];
			end else begin
				row_q <= row_inc[PosWidth-1:0];
			end
		end
	end

endmodule

FILE: test/blit_write_checker.sv
// Checker for the clipped column blit writer: watches the register port and both streams.
// Depends on ccbw_pkg for register indexes and field widths.
// It predicts every framebuffer write and compares it with what the block sends.
module blit_write_checker
	import ccbw_pkg::*;
#(
	parameter int unsigned SCREEN_LIMIT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] texel
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [21:0] pixel_address, [29:22] pixel_value, rest zero
	input  logic        m_tuser,   // [0] write_enable
	input  logic        m_tlast,   // blit_done
	output int          mismatch_count,
	output int          writes_outstanding
);

	typedef struct packed {
		logic                  write_enable;
		logic [AddrWidth-1:0]  pixel_address;
		logic [TexelWidth-1:0] pixel_value;
		logic                  blit_done;
	} fb_write_t;

	logic [CfgWidth-1:0] scr_w, scr_h, tex_w, tex_h, org_x, org_y;
	logic [PosWidth-1:0] row_pos, col_pos;
	fb_write_t           writes_due[$];
	int                  mismatches = 0;

	assign mismatch_count = mismatches;

	function automatic int texture_extent(input logic [CfgWidth-1:0] v);
		if (v == '0) return 1;
		if (v > 12'd2048) return 2048;
		return int'(v);
	endfunction

	function automatic int screen_extent(input logic [CfgWidth-1:0] v);
		return (v > SCREEN_LIMIT) ? int'(SCREEN_LIMIT) : int'(v);
	endfunction

	// Works out the write for one texel and steps the texture position.
	function automatic fb_write_t place_texel(input logic [TexelWidth-1:0] texel);
		fb_write_t w;
		int        tw, th, sw, sh, x, y;
		logic      on_screen, last_row, last_col;
		tw = texture_extent(tex_w);
		th = texture_extent(tex_h);
		sw = screen_extent(scr_w);
		sh = screen_extent(scr_h);
		x = int'($signed(org_x)) + int'(col_pos);
		y = int'($signed(org_y)) + int'(row_pos);
		on_screen = (x >= 0) && (y >= 0) && (x < sw) && (y < sh);
		last_row = (int'(row_pos) + 1) >= th;
		last_col = (int'(col_pos) + 1) >= tw;
		w.write_enable = on_screen;
		w.pixel_address = on_screen ? AddrWidth'(y * sw + x) : '0;
		w.pixel_value = texel;
		w.blit_done = last_row && last_col;
		if (w.blit_done) begin
			row_pos = '0;
			col_pos = '0;
		end else if (last_row) begin
			row_pos = '0;
			col_pos = col_pos + 1'b1;
		end else begin
			row_pos = row_pos + 1'b1;
		end
		return w;
	endfunction

	function automatic void note_failure(input string what, input fb_write_t want,
			input fb_write_t got, input logic [31:0] raw);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected we=%0b addr=%0d value=%0d done=%0b, got we=%0b addr=%0d value=%0d done=%0b tdata=%h",
				what, want.write_enable, want.pixel_address, want.pixel_value, want.blit_done,
				got.write_enable, got.pixel_address, got.pixel_value, got.blit_done, raw);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_write_t want, got;
		if (!arst_n) begin
			scr_w = 12'd320;
			scr_h = 12'd200;
			tex_w = 12'd1;
			tex_h = 12'd1;
			org_x = '0;
			org_y = '0;
			row_pos = '0;
			col_pos = '0;
			writes_due.delete();
			writes_outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[4:2]))
					REG_SCREEN_WIDTH:   scr_w = pwdata[CfgWidth-1:0];
					REG_SCREEN_HEIGHT:  scr_h = pwdata[CfgWidth-1:0];
					REG_TEXTURE_WIDTH:  tex_w = pwdata[CfgWidth-1:0];
					REG_TEXTURE_HEIGHT: tex_h = pwdata[CfgWidth-1:0];
					REG_ORIGIN_X:       org_x = pwdata[CfgWidth-1:0];
					REG_ORIGIN_Y:       org_y = pwdata[CfgWidth-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[AddrWidth-1:0],
					m_tdata[AddrWidth+TexelWidth-1:AddrWidth], m_tlast};
				if (writes_due.size() == 0) begin
					note_failure("unexpected write", '0, got, m_tdata);
				end else begin
					want = writes_due.pop_front();
					if (got !== want || m_tdata[31:AddrWidth+TexelWidth] !== '0) begin
						note_failure("write mismatch", want, got, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				writes_due.push_back(place_texel(s_tdata));
			end
			writes_outstanding <= writes_due.size();
		end
	end

endmodule

FILE: test/clipped_column_blit_writer_top_tb.sv
// Testbench top for the clipped column blit writer: clock, reset, stimulus and verdict.
// Depends on ccbw_pkg, the block itself and blit_write_checker, which does all checking.
// Stimulus is a short directed part followed by random texture geometries and texels.
module clipped_column_blit_writer_top_tb;
	import ccbw_pkg::*;

	localparam int unsigned ScreenLimit = 2048;
	// Random texels to send after the directed part.
	localparam int TargetTexels = 1050;
	// The receiver stops taking writes once, for this long, after this many writes.
	localparam int HoldAfter = 400;
	localparam int HoldCycles = 300;
	// Cycles without any transaction before the run is declared hung.
	localparam int WatchdogLimit = 4000;
	// A register index with no register behind it; writes there must be dropped.
	localparam logic [2:0] UnmappedIndex = 3'd6;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        s_tvalid, s_tready;
	logic [7:0]  s_tdata;    // [7:0] texel
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;    // [21:0] pixel_address, [29:22] pixel_value, rest zero
	logic        m_tuser;    // [0] write_enable
	logic        m_tlast;    // blit_done
	int          mismatch_count, writes_outstanding;

	// Sender and receiver each switch between gappy traffic and stretches at full rate.
	bit          sender_quiet, receiver_quiet;
	int          idle_cycles;

	clipped_column_blit_writer_top #(.MAX_SCREEN_DIM(ScreenLimit)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	blit_write_checker #(.SCREEN_LIMIT(ScreenLimit)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.mismatch_count(mismatch_count), .writes_outstanding(writes_outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Texture sizes are mostly small so that whole blits finish and raise tlast. The
	// rest covers a size of zero (taken as one), the 2048 limit and values above it.
	function automatic logic [CfgWidth-1:0] pick_texture_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return CfgWidth'($urandom_range(2049, 4095));
		if (r < 13) return 12'd2048;
		return CfgWidth'($urandom_range(1, 8));
	endfunction

	// Screen sizes are mostly small so that clipping happens on every edge, with zero
	// (clips everything), the limit and oversized values mixed in.
	function automatic logic [CfgWidth-1:0] pick_screen_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return 12'd2048;
		if (r < 14) return CfgWidth'($urandom_range(2049, 4095));
		if (r < 20) return CfgWidth'($urandom_range(1, 4095));
		return CfgWidth'($urandom_range(1, 64));
	endfunction

	// Origins cluster around the small screens, partly off the top or left, with the
	// signed extremes and the whole range now and then.
	function automatic logic [CfgWidth-1:0] pick_origin();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
		if (r < 15) return CfgWidth'($urandom());
		return CfgWidth'($urandom_range(0, 72) - 12);
	endfunction

	// One register write: a setup cycle, then the access cycle, which completes at the
	// first edge with pready high. The bits above the register width carry noise, since
	// the block must ignore them.
	task automatic cfg_write(input logic [2:0] index, input logic [CfgWidth-1:0] value);
		logic [31:0] noise;
		noise = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= {noise[31:CfgWidth], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [CfgWidth-1:0] sw, input logic [CfgWidth-1:0] sh,
			input logic [CfgWidth-1:0] tw, input logic [CfgWidth-1:0] th,
			input logic [CfgWidth-1:0] ox, input logic [CfgWidth-1:0] oy);
		cfg_write(REG_SCREEN_WIDTH, sw);
		cfg_write(REG_SCREEN_HEIGHT, sh);
		cfg_write(REG_TEXTURE_WIDTH, tw);
		cfg_write(REG_TEXTURE_HEIGHT, th);
		cfg_write(REG_ORIGIN_X, ox);
		cfg_write(REG_ORIGIN_Y, oy);
	endtask

	// Offers one texel and returns at the edge where the transaction completes. With a
	// gap of zero tvalid simply stays high into the next call, so it is never lowered
	// and raised within one step.
	task automatic send_texel(input logic [7:0] texel);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= texel;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap(sender_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering texels and waits until every predicted write has come out. The
	// checker's count is registered, so the first edge is always waited.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (writes_outstanding != 0) @(posedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		int                  texels_sent, count, area, tw_eff, th_eff;
		logic [CfgWidth-1:0] cur_tw, cur_th, value;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		sender_quiet = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: a one by one texture at the screen origin, so every texel is
		// a whole blit written at address zero.
		send_texel(8'h00);
		send_texel(8'hFF);
		wait_until_drained();

		// Largest screen with the texture at its far corner. A texture width of zero acts
		// as one and an oversized height as 2048; the first texel lands on the very last
		// address and the ones below it fall off the bottom.
		set_geometry(12'd2048, 12'd2048, 12'd0, 12'd4095, 12'h7FF, 12'h7FF);
		send_texel(8'hFF);
		send_texel(8'h00);
		send_texel(8'hA5);
		wait_until_drained();
		// Shrinking the height below the current row mid-blit: the next texel counts as
		// being on the last row of the last column and ends the texture.
		cfg_write(REG_TEXTURE_HEIGHT, 12'd2);
		send_texel(8'h5A);
		wait_until_drained();

		// A screen of width zero clips every texel of a two by two texture.
		set_geometry(12'd0, 12'd5, 12'd2, 12'd2, 12'd0, 12'd0);
		repeat (4) send_texel(8'($urandom()));
		wait_until_drained();

		// An oversized screen width acts as the limit and sets the row pitch, while the
		// texture hangs one texel off the top and left edges.
		set_geometry(12'd4095, 12'd3, 12'd3, 12'd3, 12'hFFF, 12'hFFF);
		repeat (9) send_texel(8'($urandom()));
		wait_until_drained();
		cur_tw = 12'd3;
		cur_th = 12'd3;

		// Random phases. Each one changes some registers while the block is idle and then
		// streams a number of texels, usually whole blits, sometimes stopping mid-blit so
		// that the next geometry starts from leftover position counters.
		texels_sent = 0;
		while (texels_sent < TargetTexels) begin
			if ($urandom_range(0, 9) < 7) cfg_write(REG_SCREEN_WIDTH, pick_screen_dim());
			if ($urandom_range(0, 9) < 7) cfg_write(REG_SCREEN_HEIGHT, pick_screen_dim());
			if ($urandom_range(0, 9) < 7) begin
				cur_tw = pick_texture_dim();
				cfg_write(REG_TEXTURE_WIDTH, cur_tw);
			end
			if ($urandom_range(0, 9) < 7) begin
				cur_th = pick_texture_dim();
				cfg_write(REG_TEXTURE_HEIGHT, cur_th);
			end
			if ($urandom_range(0, 9) < 7) cfg_write(REG_ORIGIN_X, pick_origin());
			if ($urandom_range(0, 9) < 7) cfg_write(REG_ORIGIN_Y, pick_origin());
			if ($urandom_range(0, 19) == 0) begin
				value = CfgWidth'($urandom());
				cfg_write(UnmappedIndex | 3'($urandom_range(0, 1)), value);
			end

			tw_eff = (cur_tw == '0) ? 1 : ((cur_tw > 12'd2048) ? 2048 : int'(cur_tw));
			th_eff = (cur_th == '0) ? 1 : ((cur_th > 12'd2048) ? 2048 : int'(cur_th));
			area = tw_eff * th_eff;
			if (area <= 64) begin
				count = area * $urandom_range(1, 4);
				if ($urandom_range(0, 3) == 0) count += $urandom_range(0, area - 1);
			end else begin
				count = $urandom_range(20, 60);
			end
			// The last phase stops at the target so the total stays close to it.
			if (count > TargetTexels - texels_sent) count = TargetTexels - texels_sent;

			sender_quiet = ($urandom_range(0, 4) == 0);
			repeat (count) send_texel(8'($urandom()));
			texels_sent += count;
			wait_until_drained();
		end

		// A stray write after the last drain would still be caught here.
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver. It takes writes with random gaps and, once, holds tready low for a long
	// stretch while the sender is still offering texels, so the pipeline fills up and
	// must stall its input.
	initial begin
		int gap, results_seen;
		bit held;
		results_seen = 0;
		held = 1'b0;
		receiver_quiet = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			if (results_seen % 100 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
			if (!held && results_seen >= HoldAfter && s_tvalid) begin
				held = 1'b1;
				gap = HoldCycles;
			end else begin
				gap = pick_gap(receiver_quiet);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog: any transaction on either stream or the register port restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (arst_n && idle_cycles >= WatchdogLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
